### rtl/core/tpm_pkg.sv
`timescale 1ns / 1ps
package tpm_pkg;

  localparam int unsigned QueueDepth  = 8;
  localparam int unsigned StampWidth  = 48;
  localparam int unsigned HandleWidth = 16;
  localparam int unsigned MaxResults  = 9;
  localparam int unsigned CmdDepth    = 2;

  localparam logic [15:0] TolReset = 16'd100;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_META  = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef enum logic [0:0] {
    REG_PAIRING   = 1'b0,
    REG_TOLERANCE = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SCAN,
    ST_RELEASE,
    ST_PRUNE,
    ST_AFTER,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    PH_END,
    PH_PUSH,
    PH_CLEAR
  } phase_e;

endpackage

### rtl/core/tpm_front.sv
`timescale 1ns / 1ps
module tpm_front #(
  parameter int unsigned StampWidth  = tpm_pkg::StampWidth,
  parameter int unsigned HandleWidth = tpm_pkg::HandleWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             operation_i,
  input  logic [StampWidth-1:0]  stamp_i,
  input  logic [HandleWidth-1:0] handle_i,
  input  logic                   has_metadata_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_pop_i,
  output logic [1:0]             cmd_op_o,
  output logic [StampWidth-1:0]  cmd_stamp_o,
  output logic [HandleWidth-1:0] cmd_handle_o,
  output logic                   cmd_has_o
);
  import tpm_pkg::*;

  localparam int unsigned EW = 3 + StampWidth + HandleWidth;

  logic [EW-1:0] mem_q [CmdDepth];
  logic          wr_q, wr_d, rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  assign busy        = (cnt_q == 2'(CmdDepth));
  assign push        = start && !busy;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign {cmd_op_o, cmd_stamp_o, cmd_handle_o, cmd_has_o} = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push;
    rd_d  = rd_q ^ pop;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= {operation_i, stamp_i, handle_i, has_metadata_i};
    end
  end

endmodule

### rtl/core/tpm_back.sv
`timescale 1ns / 1ps
module tpm_back #(
  parameter int unsigned QueueDepth  = tpm_pkg::QueueDepth,
  parameter int unsigned StampWidth  = tpm_pkg::StampWidth,
  parameter int unsigned HandleWidth = tpm_pkg::HandleWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pairing_i,
  input  logic [15:0]            tolerance_i,
  input  logic                   cmd_valid_i,
  output logic                   cmd_pop_o,
  input  logic [1:0]             cmd_op_i,
  input  logic [StampWidth-1:0]  cmd_stamp_i,
  input  logic [HandleWidth-1:0] cmd_handle_i,
  input  logic                   cmd_has_i,
  output logic                   result_valid_o,
  output logic [HandleWidth-1:0] frame_handle_o,
  output logic [HandleWidth-1:0] meta_handle_o,
  output logic                   attached_o,
  output logic                   unpaired_early_o,
  output logic                   last_o
);
  import tpm_pkg::*;

  localparam int unsigned IW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam int unsigned RW = $clog2(MaxResults + 1);
  localparam int unsigned DW = StampWidth + 1;

  logic [StampWidth-1:0]  fs_q [QueueDepth];
  logic [HandleWidth-1:0] fh_q [QueueDepth];
  logic [StampWidth-1:0]  ms_q [QueueDepth];
  logic [HandleWidth-1:0] mh_q [QueueDepth];
  logic [CW-1:0]          fcnt_q, mcnt_q, idx_q;

  state_e                 state_q, state_d;
  phase_e                 phase_q;
  logic                   flush_q, hit_q, later_q;
  logic [StampWidth-1:0]  st_q, f_q;
  logic [HandleWidth-1:0] h_q;

  // pending result, held back one step so last can be marked
  logic                   pend_q;
  logic [HandleWidth-1:0] pfh_q, pmh_q;
  logic                   patt_q, pearly_q;
  logic [RW-1:0]          rcnt_q;

  logic                   rv_q, att_q, early_q, last_q;
  logic [HandleWidth-1:0] ofh_q, omh_q;

  logic signed [DW-1:0]   diff, tol_s;
  logic                   in_tol, is_later, is_stale, scan_end;
  logic [IW-1:0]          idx;

  assign idx      = idx_q[IW-1:0];
  assign diff     = $signed({ms_q[idx][StampWidth-1], ms_q[idx]})
                  - $signed({f_q[StampWidth-1], f_q});
  assign tol_s    = $signed({{(DW-16){1'b0}}, tolerance_i});
  assign in_tol   = (diff <= tol_s) && (diff >= -tol_s);
  assign is_later = (diff > 0);
  assign is_stale = (diff < -tol_s);
  assign scan_end = (idx_q >= mcnt_q);

  assign cmd_pop_o        = (state_q == ST_IDLE) && cmd_valid_i;
  assign result_valid_o   = rv_q;
  assign frame_handle_o   = ofh_q;
  assign meta_handle_o    = omh_q;
  assign attached_o       = att_q;
  assign unpaired_early_o = early_q;
  assign last_o           = last_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_op_i)
            OP_FRAME: state_d = pairing_i ? ST_MATCH : ST_FINISH;
            OP_META:  state_d = ST_MATCH;
            OP_FLUSH: state_d = ST_MATCH;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_MATCH:   state_d = (fcnt_q == '0) ? ST_AFTER : ST_SCAN;
      ST_SCAN:    state_d = (scan_end || in_tol) ? ST_RELEASE : ST_SCAN;
      ST_RELEASE: begin
        if (hit_q || flush_q || later_q || fcnt_q == CW'(QueueDepth)) begin
          state_d = ST_PRUNE;
        end else begin
          state_d = ST_AFTER;
        end
      end
      ST_PRUNE:   state_d = scan_end ? ST_MATCH : ST_PRUNE;
      ST_AFTER:   state_d = (phase_q == PH_PUSH) ? ST_MATCH : ST_FINISH;
      ST_FINISH:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control and queue bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic                   put;
    logic [HandleWidth-1:0] nfh, nmh;
    logic                   natt, nearly;
    logic                   fin, adv;
    if (!rst_ni) begin
      fcnt_q  <= '0;
      mcnt_q  <= '0;
      idx_q   <= '0;
      phase_q <= PH_END;
      flush_q <= 1'b0;
      hit_q   <= 1'b0;
      later_q <= 1'b0;
      pend_q  <= 1'b0;
      rcnt_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      put    = 1'b0;
      nfh    = '0;
      nmh    = '0;
      natt   = 1'b0;
      nearly = 1'b0;
      fin    = 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_op_i)
              OP_FRAME: begin
                if (!pairing_i) begin
                  put = 1'b1;
                  nfh = cmd_handle_i;
                end else if (fcnt_q == CW'(QueueDepth)) begin
                  flush_q <= 1'b1;
                  phase_q <= PH_PUSH;
                end else begin
                  fs_q[fcnt_q[IW-1:0]] <= cmd_stamp_i;
                  fh_q[fcnt_q[IW-1:0]] <= cmd_handle_i;
                  fcnt_q  <= fcnt_q + 1'b1;
                  flush_q <= 1'b0;
                  phase_q <= PH_END;
                end
              end
              OP_META: begin
                if (cmd_has_i) begin
                  if (mcnt_q == CW'(QueueDepth)) begin
                    for (int k = 0; k < QueueDepth - 1; k++) begin
                      ms_q[k] <= ms_q[k+1];
                      mh_q[k] <= mh_q[k+1];
                    end
                    ms_q[QueueDepth-1] <= cmd_stamp_i;
                    mh_q[QueueDepth-1] <= cmd_handle_i;
                  end else begin
                    ms_q[mcnt_q[IW-1:0]] <= cmd_stamp_i;
                    mh_q[mcnt_q[IW-1:0]] <= cmd_handle_i;
                    mcnt_q <= mcnt_q + 1'b1;
                  end
                end
                flush_q <= 1'b0;
                phase_q <= PH_END;
              end
              OP_FLUSH: begin
                flush_q <= 1'b1;
                phase_q <= PH_CLEAR;
              end
              default: ;
            endcase
          end
        end
        ST_MATCH: begin
          f_q     <= fs_q[0];
          idx_q   <= '0;
          hit_q   <= 1'b0;
          later_q <= 1'b0;
        end
        ST_SCAN: begin
          if (!scan_end) begin
            if (in_tol) begin
              hit_q <= 1'b1;
            end else begin
              later_q <= later_q | is_later;
              idx_q   <= idx_q + 1'b1;
            end
          end
        end
        ST_RELEASE: begin
          if (hit_q || flush_q || later_q || fcnt_q == CW'(QueueDepth)) begin
            put    = 1'b1;
            nfh    = fh_q[0];
            nmh    = hit_q ? mh_q[idx] : '0;
            natt   = hit_q;
            nearly = !hit_q && !flush_q;
            if (hit_q) begin
              for (int k = 0; k < QueueDepth - 1; k++) begin
                if (k >= int'(idx_q)) begin
                  ms_q[k] <= ms_q[k+1];
                  mh_q[k] <= mh_q[k+1];
                end
              end
              mcnt_q <= mcnt_q - 1'b1;
            end
            for (int k = 0; k < QueueDepth - 1; k++) begin
              fs_q[k] <= fs_q[k+1];
              fh_q[k] <= fh_q[k+1];
            end
            fcnt_q <= fcnt_q - 1'b1;
            idx_q  <= '0;
          end
        end
        ST_PRUNE: begin
          if (!scan_end) begin
            if (is_stale) begin
              for (int k = 0; k < QueueDepth - 1; k++) begin
                if (k >= int'(idx_q)) begin
                  ms_q[k] <= ms_q[k+1];
                  mh_q[k] <= mh_q[k+1];
                end
              end
              mcnt_q <= mcnt_q - 1'b1;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_AFTER: begin
          case (phase_q)
            PH_PUSH: begin
              fs_q[fcnt_q[IW-1:0]] <= st_q;
              fh_q[fcnt_q[IW-1:0]] <= h_q;
              fcnt_q  <= fcnt_q + 1'b1;
              flush_q <= 1'b0;
              phase_q <= PH_END;
            end
            PH_CLEAR: mcnt_q <= '0;
            default:  ;
          endcase
        end
        ST_FINISH: fin = 1'b1;
        default: ;
      endcase

      // results beyond the limit are dropped
      adv = put && (rcnt_q < RW'(MaxResults));

      // the held result leaves when the next one arrives or the command ends
      rv_q <= (fin || adv) && pend_q;
      if ((fin || adv) && pend_q) begin
        ofh_q   <= pfh_q;
        omh_q   <= pmh_q;
        att_q   <= patt_q;
        early_q <= pearly_q;
        last_q  <= fin;
      end

      if (fin) begin
        pend_q <= 1'b0;
        rcnt_q <= '0;
      end else if (adv) begin
        pend_q   <= 1'b1;
        pfh_q    <= nfh;
        pmh_q    <= nmh;
        patt_q   <= natt;
        pearly_q <= nearly;
        rcnt_q   <= rcnt_q + 1'b1;
      end
    end
  end

  // latched command fields kept for the deferred frame push
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      st_q <= cmd_stamp_i;
      h_q  <= cmd_handle_i;
    end
  end

endmodule

### rtl/core/timestamp_pair_matcher.sv
`timescale 1ns / 1ps
// timestamp pair matcher: pairs queued frames with metadata items by stamp
//
// command channel: a transaction is taken when start is high and busy low;
// operation_i selects frame push, metadata push or flush. a two-entry
// command queue in the front end takes commands while the back end works.
// result channel: result_valid_o marks each emitted frame for one cycle;
// last_o flags the final result of a command. the receiver cannot stall.
// configuration: apb port, pairing enable at 0x0, tolerance at 0x4.
// sequencing: the back end handles one command at a time. for each released
// frame it scans the metadata entries one by one for a match and then
// checks them one by one for pruning, all through the single shared stamp
// subtractor in the back-end sequencer.
// each result shows up in the cycle after the next one is formed or after
// the command ends.
// reset: both queues empty, pairing on, tolerance 100 ticks.
module timestamp_pair_matcher #(
  parameter int unsigned QueueDepth  = tpm_pkg::QueueDepth,
  parameter int unsigned StampWidth  = tpm_pkg::StampWidth,
  parameter int unsigned HandleWidth = tpm_pkg::HandleWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             operation_i,
  input  logic [StampWidth-1:0]  stamp_i,
  input  logic [HandleWidth-1:0] handle_i,
  input  logic                   has_metadata_i,
  output logic                   result_valid_o,
  output logic [HandleWidth-1:0] frame_handle_o,
  output logic [HandleWidth-1:0] meta_handle_o,
  output logic                   attached_o,
  output logic                   unpaired_early_o,
  output logic                   last_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import tpm_pkg::*;

  logic                   pairing_q;
  logic [15:0]            tol_q;
  logic                   cmd_valid, cmd_pop, cmd_has;
  logic [1:0]             cmd_op;
  logic [StampWidth-1:0]  cmd_stamp;
  logic [HandleWidth-1:0] cmd_handle;

  // register file, written in the apb access phase
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairing_q <= 1'b1;
      tol_q     <= TolReset;
    end else if (psel && penable && pwrite) begin
      case (reg_e'(paddr[2]))
        REG_PAIRING:   pairing_q <= pwdata[0];
        REG_TOLERANCE: tol_q     <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_PAIRING:   prdata = {31'd0, pairing_q};
      REG_TOLERANCE: prdata = {16'd0, tol_q};
      default:       prdata = '0;
    endcase
  end

  // front end: command queue
  tpm_front #(
    .StampWidth (StampWidth),
    .HandleWidth(HandleWidth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .stamp_i       (stamp_i),
    .handle_i      (handle_i),
    .has_metadata_i(has_metadata_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_pop_i     (cmd_pop),
    .cmd_op_o      (cmd_op),
    .cmd_stamp_o   (cmd_stamp),
    .cmd_handle_o  (cmd_handle),
    .cmd_has_o     (cmd_has)
  );

  // back end: queues and matching sequencer
  tpm_back #(
    .QueueDepth (QueueDepth),
    .StampWidth (StampWidth),
    .HandleWidth(HandleWidth)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pairing_i       (pairing_q),
    .tolerance_i     (tol_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_pop_o       (cmd_pop),
    .cmd_op_i        (cmd_op),
    .cmd_stamp_i     (cmd_stamp),
    .cmd_handle_i    (cmd_handle),
    .cmd_has_i       (cmd_has),
    .result_valid_o  (result_valid_o),
    .frame_handle_o  (frame_handle_o),
    .meta_handle_o   (meta_handle_o),
    .attached_o      (attached_o),
    .unpaired_early_o(unpaired_early_o),
    .last_o          (last_o)
  );

endmodule

### dv/tpm_checker.sv
`timescale 1ns / 1ps
module tpm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [47:0] stamp_i,
  input  logic [15:0] handle_i,
  input  logic        has_metadata_i,
  input  logic        result_valid_o,
  input  logic [15:0] frame_handle_o,
  input  logic [15:0] meta_handle_o,
  input  logic        attached_o,
  input  logic        unpaired_early_o,
  input  logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          outstanding
);
  import tpm_pkg::*;

  typedef struct packed {
    logic [15:0] frame_handle;
    logic [15:0] meta_handle;
    logic        attached;
    logic        unpaired_early;
    logic        last;
  } pairing_t;

  pairing_t    pending_pairs[$];
  longint      fr_stamp[QueueDepth];
  logic [15:0] fr_handle[QueueDepth];
  int          fr_cnt;
  longint      mt_stamp[QueueDepth];
  logic [15:0] mt_handle[QueueDepth];
  int          mt_cnt;
  logic        pairing_on;
  logic [15:0] tolerance;
  int          cmd_results;

  assign outstanding = pending_pairs.size();

  function automatic longint widen(logic [47:0] v);
    return {{16{v[47]}}, v};
  endfunction

  task automatic emit(logic [15:0] fh, logic [15:0] mh, logic att, logic early);
    pairing_t p;
    if (cmd_results < MaxResults) begin
      p.frame_handle   = fh;
      p.meta_handle    = mh;
      p.attached       = att;
      p.unpaired_early = early;
      p.last           = 1'b0;
      pending_pairs.push_back(p);
      cmd_results++;
    end
  endtask

  task automatic drop_meta(int idx);
    for (int k = idx; k + 1 < mt_cnt; k++) begin
      mt_stamp[k]  = mt_stamp[k+1];
      mt_handle[k] = mt_handle[k+1];
    end
    mt_cnt--;
  endtask

  task automatic release_frames(logic flush);
    longint f;
    longint m;
    longint d;
    int     hit;
    logic   later;
    int     i;
    while (fr_cnt > 0) begin
      f     = fr_stamp[0];
      hit   = -1;
      later = 1'b0;
      for (i = 0; i < mt_cnt; i++) begin
        m = mt_stamp[i];
        d = (m > f) ? m - f : f - m;
        if (d <= longint'(tolerance)) begin
          hit = i;
          break;
        end
        if (m > f) later = 1'b1;
      end
      if (hit >= 0) begin
        emit(fr_handle[0], mt_handle[hit], 1'b1, 1'b0);
        drop_meta(hit);
      end else if (flush || later || fr_cnt >= QueueDepth) begin
        emit(fr_handle[0], '0, 1'b0, !flush);
      end else begin
        break;
      end
      for (int k = 0; k + 1 < fr_cnt; k++) begin
        fr_stamp[k]  = fr_stamp[k+1];
        fr_handle[k] = fr_handle[k+1];
      end
      fr_cnt--;
      // stale metadata behind the released frame goes away
      i = 0;
      while (i < mt_cnt) begin
        if (f > mt_stamp[i] && f - mt_stamp[i] > longint'(tolerance)) drop_meta(i);
        else i++;
      end
    end
  endtask

  task automatic predict_command(logic [1:0] op, logic [47:0] st, logic [15:0] h,
                                 logic has);
    int first;
    first       = pending_pairs.size();
    cmd_results = 0;
    case (op)
      OP_FRAME: begin
        if (!pairing_on) begin
          emit(h, '0, 1'b0, 1'b0);
        end else begin
          if (fr_cnt >= QueueDepth) release_frames(1'b1);
          if (fr_cnt < QueueDepth) begin
            fr_stamp[fr_cnt]  = widen(st);
            fr_handle[fr_cnt] = h;
            fr_cnt++;
          end
          release_frames(1'b0);
        end
      end
      OP_META: begin
        if (has) begin
          if (mt_cnt >= QueueDepth) drop_meta(0);
          mt_stamp[mt_cnt]  = widen(st);
          mt_handle[mt_cnt] = h;
          mt_cnt++;
        end
        release_frames(1'b0);
      end
      OP_FLUSH: begin
        release_frames(1'b1);
        mt_cnt = 0;
      end
      default: ;
    endcase
    if (pending_pairs.size() > first) pending_pairs[pending_pairs.size()-1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pairing_t exp_p;
    pairing_t act_p;
    if (!rst_ni) begin
      pending_pairs.delete();
      fr_cnt     = 0;
      mt_cnt     = 0;
      pairing_on = 1'b1;
      tolerance  = TolReset;
      fail_count = 0;
    end else begin
      if (result_valid_o) begin
        act_p = '{frame_handle_o, meta_handle_o, attached_o, unpaired_early_o, last_o};
        if (pending_pairs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", act_p);
        end else begin
          exp_p = pending_pairs.pop_front();
          if (exp_p !== act_p) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", exp_p, act_p);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (reg_e'(paddr[2]) == REG_PAIRING) pairing_on = pwdata[0];
        else tolerance = pwdata[15:0];
      end
      if (start && !busy) predict_command(operation_i, stamp_i, handle_i, has_metadata_i);
    end
  end

endmodule

### dv/timestamp_pair_matcher_tb.sv
`timescale 1ns / 1ps
module timestamp_pair_matcher_tb;
  import tpm_pkg::*;

  localparam int CycleLimit = 300000;
  localparam longint StampMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint StampMin = -64'sh0000_8000_0000_0000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = '0;
  logic [47:0] stamp_i = '0;
  logic [15:0] handle_i = '0;
  logic        has_metadata_i = 1'b0;
  logic        result_valid_o;
  logic [15:0] frame_handle_o;
  logic [15:0] meta_handle_o;
  logic        attached_o;
  logic        unpaired_early_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int     fail_count;
  int     outstanding;
  int     cycles = 0;
  int     idle_pct = 0;   // chance of a sender gap after each transaction
  longint frame_clock;    // running stamp of the random frame stream
  longint last_frame;

  always #2 clk_i = ~clk_i;

  timestamp_pair_matcher DUT (.*);

  tpm_checker u_checker (.*);

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one command transaction, start stays high until busy drops
  task automatic send_cmd(op_e op, longint st, logic [15:0] h, logic has);
    int gap;
    start          <= 1'b1;
    operation_i    <= op;
    stamp_i        <= st[47:0];
    handle_i       <= h;
    has_metadata_i <= has;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // setup then access phase, pready is tied high by the block
  task automatic write_reg(reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain everything, then allow for commands that produce no result
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic random_cmd();
    int     pick;
    longint jitter;
    pick   = $urandom_range(0, 99);
    jitter = longint'($urandom_range(0, 400)) - 200;
    if (pick < 40) begin
      frame_clock += $urandom_range(300, 2000);
      last_frame  = frame_clock;
      send_cmd(OP_FRAME, frame_clock, 16'($urandom), 1'b1);
    end else if (pick < 70) begin
      send_cmd(OP_META, last_frame + jitter, 16'($urandom), $urandom_range(0, 9) != 0);
    end else if (pick < 80) begin
      // metadata ahead of the stream, exposes a missing twin
      send_cmd(OP_META, frame_clock + 2500 + jitter, 16'($urandom), 1'b1);
    end else if (pick < 86) begin
      send_cmd(OP_FLUSH, 0, 16'($urandom), 1'($urandom));
    end else if (pick < 89) begin
      send_cmd(op_e'(2'b11), {16'h0, $urandom, 16'($urandom)}, 16'($urandom), 1'($urandom));
    end else begin
      // full width stamps, any sign
      send_cmd(op_e'($urandom_range(0, 1)),
               {{16{1'b0}}, 32'($urandom), 16'($urandom)}, 16'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: tolerance edge, extremes, full queues, ignored commands
    send_cmd(OP_FRAME, 0, 16'h0000, 1'b0);
    send_cmd(OP_META, 50, 16'hFFFF, 1'b1);
    send_cmd(OP_FRAME, StampMax, 16'hFFFF, 1'b1);
    send_cmd(OP_META, StampMax, 16'h1234, 1'b0);
    send_cmd(OP_META, StampMax - 100, 16'h00AA, 1'b1);
    send_cmd(OP_FRAME, StampMin, 16'h0001, 1'b0);
    send_cmd(OP_META, StampMin + 101, 16'h0002, 1'b1);
    send_cmd(OP_FLUSH, 0, 16'h0, 1'b0);
    send_cmd(op_e'(2'b11), StampMax, 16'hFFFF, 1'b1);
    for (int k = 1; k <= 9; k++) send_cmd(OP_FRAME, 1000 * k, 16'(k), 1'b0);
    for (int k = 0; k < 9; k++) send_cmd(OP_META, 20000 + 7 * k, 16'(16'h100 + k), 1'b1);
    send_cmd(OP_FLUSH, 0, 16'h0, 1'b0);
    wait_quiet();

    // config phases, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_TOLERANCE, 0);     write_reg(REG_PAIRING, 1); idle_pct = 65; end
        1: begin write_reg(REG_TOLERANCE, 65535); write_reg(REG_PAIRING, 0); idle_pct = 0;  end
        2: begin write_reg(REG_TOLERANCE, 65535); write_reg(REG_PAIRING, 1); idle_pct = 34; end
        3: begin write_reg(REG_TOLERANCE, 100);   write_reg(REG_PAIRING, 1); idle_pct = 65; end
        default: begin
          write_reg(REG_TOLERANCE, $urandom_range(0, 300));
          idle_pct = 0;
        end
      endcase
      frame_clock = longint'($urandom_range(0, 1000000)) - 500000;
      last_frame  = frame_clock;
      for (int n = 0; n < 16; n++) random_cmd();
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
